>>> design/cbq_pkg.sv
// Package for the cascaded biquad filter: request kinds, register indexes,
// coefficient slot codes and the sequencer state type.
// No dependencies; used by cascaded_biquad_filter.
package cbq_pkg;

	// Fixed field widths of the request and configuration ports.
	localparam int KIND_W     = 2;
	localparam int CIDX_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int NSEC_REG_W = 5;

	// Coefficient words per section.
	localparam int SLOTS = 5;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_COEFF  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SECS = 2'd2;

	// Coefficient slots within a section: a0, a1, a2, b1, b2.
	typedef logic [2:0] slot_t;
	localparam slot_t SLOT_A0 = 3'd0;
	localparam slot_t SLOT_A1 = 3'd1;
	localparam slot_t SLOT_A2 = 3'd2;
	localparam slot_t SLOT_B1 = 3'd3;
	localparam slot_t SLOT_B2 = 3'd4;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

endpackage

>>> design/cbq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; instantiated by cascaded_biquad_filter.
module cbq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port, and a read port whose data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/cascaded_biquad_filter.sv
// Cascaded direct-form-I biquad filter. A filtered sample runs from acceptance to the result
// register through n active sections (one coefficient read and one multiply-accumulate
// per cycle on a shared MAC); bypass, silence and n = 0 go straight to the result register.
// Coefficient writes and clears act on acceptance. One request is in work at a time.
// Reset clears the control registers and the valid bits of both memories, so coefficients and
// history read as zero at once; there is no clearing pass.
module cascaded_biquad_filter
	import cbq_pkg::*;
#(
	parameter int MAX_SECTIONS = 20,
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEFF_WIDTH  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [KIND_W-1:0]              kind,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic [CIDX_W-1:0]              coeff_index,
	input  logic signed [COEFF_WIDTH-1:0]  coeff_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input  logic                           cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int CW     = COEFF_WIDTH;
	localparam int NCOEF  = SLOTS * MAX_SECTIONS;
	localparam int CA_W   = NCOEF > 1 ? $clog2(NCOEF) : 1;
	localparam int SEC_W  = MAX_SECTIONS > 1 ? $clog2(MAX_SECTIONS) : 1;
	localparam int NS_W   = $clog2(MAX_SECTIONS + 1);
	localparam int PW     = SW + CW;
	localparam int AW     = PW + 3;
	localparam int CF     = CW - 4;
	localparam int HW     = 4 * SW;
	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (CF - 1);
	localparam logic signed [AW-1:0] SMAX = (AW'(1) <<< (SW - 1)) - AW'(1);
	localparam logic signed [AW-1:0] SMIN = -(AW'(1) <<< (SW - 1));

	// Configuration registers.
	logic                  bypass_q;
	logic                  zero_q;
	logic [NSEC_REG_W-1:0] nsec_q;
	logic [NS_W-1:0]       n_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
			zero_q   <= 1'b0;
			nsec_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BYPASS:   bypass_q <= cfg_data[0];
				REG_ZERO:     zero_q   <= cfg_data[0];
				REG_NUM_SECS: nsec_q   <= cfg_data[NSEC_REG_W-1:0];
				default:      ;
			endcase
		end
	end

	// Section counts above the maximum act as the maximum.
	assign n_act = (int'(nsec_q) > MAX_SECTIONS) ? NS_W'(MAX_SECTIONS) : NS_W'(nsec_q);

	// Request handshake decode.
	state_t state_q, state_d;
	logic   in_acc, out_busy, is_sample, is_coeff, is_clear, direct_out, start_run;
	logic   coeff_ok;

	assign out_busy  = out_valid & out_stall;
	assign in_stall  = (state_q != ST_IDLE) | out_busy;
	assign in_acc    = in_valid & ~in_stall;
	assign is_sample = in_acc & (kind == KIND_SAMPLE);
	assign is_coeff  = in_acc & (kind == KIND_COEFF);
	assign is_clear  = in_acc & (kind == KIND_CLEAR);
	assign direct_out = is_sample & (bypass_q | zero_q | (n_act == '0));
	assign start_run  = is_sample & ~direct_out;
	assign coeff_ok   = int'(coeff_index) < NCOEF;

	// Issue stage: section and slot counters. Slots run a1, a2, b1, b2 and then a0,
	// so the section input from the previous section is needed last.
	logic [SEC_W-1:0] sec_q;
	logic [2:0]       k_q;
	logic [CA_W-1:0]  base_q;
	slot_t            slot_cur;
	logic             issue, last_slot, last_sec, final_issue;

	assign issue       = (state_q == ST_RUN);
	assign last_slot   = (k_q == 3'd4);
	assign slot_cur    = last_slot ? SLOT_A0 : slot_t'(k_q + 3'd1);
	assign last_sec    = (int'(sec_q) + 1 == int'(n_act));
	assign final_issue = issue & last_slot & last_sec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= '0;
			k_q    <= '0;
			base_q <= '0;
		end else if (start_run) begin
			sec_q  <= '0;
			k_q    <= '0;
			base_q <= '0;
		end else if (issue) begin
			if (last_slot) begin
				k_q    <= '0;
				sec_q  <= sec_q + SEC_W'(1);
				base_q <= base_q + CA_W'(SLOTS);
			end else begin
				k_q <= k_q + 3'd1;
			end
		end
	end

	// Coefficient memory with per-word valid bits.
	logic             cvalid_q [NCOEF];
	logic [CA_W-1:0]  c_raddr;
	logic [CW-1:0]    c_rdata;

	assign c_raddr = base_q + CA_W'(slot_cur);

	cbq_ram #(.WIDTH(CW), .DEPTH(NCOEF)) u_coeff_ram (
		.clk   (clk),
		.we    (is_coeff & coeff_ok),
		.waddr (CA_W'(coeff_index)),
		.wdata (coeff_value),
		.re    (issue),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCOEF; i++) begin
				cvalid_q[i] <= 1'b0;
			end
		end else if (is_coeff & coeff_ok) begin
			cvalid_q[CA_W'(coeff_index)] <= 1'b1;
		end
	end

	// History memory: one row of x1, x2, y1, y2 per section, with valid bits.
	logic             hvalid_q [MAX_SECTIONS];
	logic             h_re, h_we, hv_rd_q;
	logic [SEC_W-1:0] h_waddr;
	logic [HW-1:0]    h_wdata, h_rdata;

	assign h_re = issue & (k_q == 3'd0);

	cbq_ram #(.WIDTH(HW), .DEPTH(MAX_SECTIONS)) u_hist_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.re    (h_re),
		.raddr (sec_q),
		.rdata (h_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SECTIONS; i++) begin
				hvalid_q[i] <= 1'b0;
			end
			hv_rd_q <= 1'b0;
		end else begin
			if (h_re) begin
				hv_rd_q <= hvalid_q[sec_q];
			end
			if (is_clear) begin
				for (int i = 0; i < MAX_SECTIONS; i++) begin
					if (i < int'(n_act)) begin
						hvalid_q[i] <= 1'b0;
					end
				end
			end else if (h_we) begin
				hvalid_q[h_waddr] <= 1'b1;
			end
		end
	end

	// Stage 1 control: read data is valid this cycle.
	logic             v_s1, cv_s1, final_s1;
	slot_t            slot_s1;
	logic [SEC_W-1:0] sec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			final_s1 <= 1'b0;
		end else begin
			v_s1     <= issue;
			final_s1 <= final_issue;
		end
	end

	always_ff @(posedge clk) begin
		cv_s1   <= cvalid_q[c_raddr];
		slot_s1 <= slot_cur;
		sec_s1  <= sec_q;
	end

	// Stage 1: operand selection and multiply.
	logic signed [SW-1:0] x_cur_q, hx1, hx2, hy1, hy2, opnd;
	logic signed [CW-1:0] coef;

	assign hx1  = hv_rd_q ? h_rdata[HW-1 -: SW]     : '0;
	assign hx2  = hv_rd_q ? h_rdata[3*SW-1 -: SW]   : '0;
	assign hy1  = hv_rd_q ? h_rdata[2*SW-1 -: SW]   : '0;
	assign hy2  = hv_rd_q ? h_rdata[SW-1:0]         : '0;
	assign coef = cv_s1 ? c_rdata : '0;

	always_comb begin
		case (slot_s1)
			SLOT_A0: opnd = x_cur_q;
			SLOT_A1: opnd = hx1;
			SLOT_A2: opnd = hx2;
			SLOT_B1: opnd = hy1;
			SLOT_B2: opnd = hy2;
			default: opnd = '0;
		endcase
	end

	logic signed [PW-1:0] prod_s2;
	logic signed [SW-1:0] kx_s2, kx1_s2, ky1_s2;
	logic                 v_s2, neg_s2, first_s2, last_s2, final_s2;
	logic [SEC_W-1:0]     sec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			last_s2  <= 1'b0;
			final_s2 <= 1'b0;
		end else begin
			v_s2     <= v_s1;
			last_s2  <= v_s1 & (slot_s1 == SLOT_A0);
			final_s2 <= final_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2  <= coef * opnd;
		neg_s2   <= (slot_s1 == SLOT_B1) | (slot_s1 == SLOT_B2);
		first_s2 <= (slot_s1 == SLOT_A1);
		sec_s2   <= sec_s1;
		// Keep what the section's write-back needs before the next row is read.
		if (slot_s1 == SLOT_A0) begin
			kx_s2  <= x_cur_q;
			kx1_s2 <= hx1;
			ky1_s2 <= hy1;
		end
	end

	// Stage 2: accumulate, b terms subtracted.
	logic signed [AW-1:0] term, acc_q;
	logic signed [SW-1:0] kx_s3, kx1_s3, ky1_s3;
	logic                 last_s3, final_s3;
	logic [SEC_W-1:0]     sec_s3;

	assign term = neg_s2 ? -AW'(prod_s2) : AW'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_s3  <= 1'b0;
			final_s3 <= 1'b0;
		end else begin
			last_s3  <= last_s2;
			final_s3 <= final_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= first_s2 ? term : acc_q + term;
		end
		sec_s3 <= sec_s2;
		kx_s3  <= kx_s2;
		kx1_s3 <= kx1_s2;
		ky1_s3 <= ky1_s2;
	end

	// Stage 3: round half up, saturate, write the history row back.
	logic signed [AW-1:0] rnd, shifted;
	logic signed [SW-1:0] y;

	assign rnd     = acc_q + HALF;
	assign shifted = rnd >>> CF;

	always_comb begin
		if (shifted > SMAX) begin
			y = SW'(SMAX);
		end else if (shifted < SMIN) begin
			y = SW'(SMIN);
		end else begin
			y = SW'(shifted);
		end
	end

	assign h_we    = last_s3;
	assign h_waddr = sec_s3;
	assign h_wdata = {kx_s3, kx1_s3, y, ky1_s3};

	// The running section input: the sample at start, then each section's output.
	always_ff @(posedge clk) begin
		if (start_run) begin
			x_cur_q <= sample_in;
		end else if (last_s3) begin
			x_cur_q <= y;
		end
	end

	// Result register.
	logic signed [SW-1:0] out_q;
	logic                 out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (direct_out | final_s3) begin
			out_valid_q <= 1'b1;
		end else if (~out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (direct_out) begin
			out_q <= (bypass_q | ~zero_q) ? sample_in : '0;
		end else if (final_s3) begin
			out_q <= y;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start_run) state_d = ST_RUN;
			ST_RUN:   if (final_issue) state_d = ST_DRAIN;
			ST_DRAIN: if (final_s3) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// The MAC pipeline is empty whenever the sequencer is idle.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(v_s1 || v_s2 || last_s3))
		else $error("MAC pipeline busy while idle");

	// A filtered result never lands on a result still waiting.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		final_s3 |-> !out_valid_q)
		else $error("result register overwritten");

	// A history row is never read and written back in the same cycle.
	a_hist_rw: assert property (@(posedge clk) disable iff (!arst_n)
		(h_we && h_re) |-> (h_waddr != sec_q))
		else $error("history read and write collide");

	// Coefficient reads stay inside the store.
	a_coeff_addr: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (int'(c_raddr) < NCOEF))
		else $error("coefficient read out of range");

endmodule
